@@ design/bsnf_pkg.sv @@
// ============================================================================
// bsnf_pkg
// Shared types and constants for the Bayer split and neighbour fill block.
// ============================================================================
package bsnf_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 15;
    localparam int unsigned VAL_W      = 19;
    localparam int unsigned COL_W      = 12;
    localparam int unsigned ROW_W      = 14;
    localparam int unsigned WID_W      = 13;
    localparam int unsigned HGT_W      = 15;
    localparam int unsigned IN_ROW_W   = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CFA    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_FLUSH  = 1'b1;

    typedef enum logic [1:0] {
        t_CH_RED   = 2'd0,
        t_CH_GREEN = 2'd1,
        t_CH_BLUE  = 2'd2
    } t_channel;

    typedef struct packed {
        logic             action;
        logic [15:0]      sample;
    } t_in_item;

    typedef struct packed {
        logic [VAL_W-1:0] red_value;
        logic [VAL_W-1:0] green_value;
        logic [VAL_W-1:0] blue_value;
        logic [COL_W-1:0] pixel_column;
        logic [ROW_W-1:0] pixel_row;
        logic             frame_last;
    } t_out_item;

    // border and position info for one emitted pixel
    typedef struct packed {
        logic             left_edge;
        logic             right_edge;
        logic             top_edge;
        logic             bottom_edge;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [1:0]       pattern;
    } t_pix_ctl;

    function automatic t_channel colour_of(input logic [1:0] pat, input logic ry,
                                           input logic cx);
        logic [1:0] pos;
        t_channel   ch;
        pos = {ry, cx};
        ch  = t_CH_GREEN;
        unique case (pat)
            2'd0: ch = (pos == 2'd0) ? t_CH_RED  : (pos == 2'd3) ? t_CH_BLUE : t_CH_GREEN;
            2'd1: ch = (pos == 2'd0) ? t_CH_BLUE : (pos == 2'd3) ? t_CH_RED  : t_CH_GREEN;
            2'd2: ch = (pos == 2'd1) ? t_CH_RED  : (pos == 2'd2) ? t_CH_BLUE : t_CH_GREEN;
            2'd3: ch = (pos == 2'd1) ? t_CH_BLUE : (pos == 2'd2) ? t_CH_RED  : t_CH_GREEN;
            default: ch = t_CH_GREEN;
        endcase
        return ch;
    endfunction

endpackage

@@ design/bsnf_stream_if.sv @@
// ============================================================================
// bsnf_stream_if
// Valid/ready channel carrying one payload of a given type.
// ============================================================================
interface bsnf_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/bsnf_ram.sv @@
// ============================================================================
// bsnf_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module bsnf_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ design/bsnf_fill.sv @@
// ============================================================================
// bsnf_fill
// Clamps the 3x3 window at the frame border and forms the three colour
// values of the centre pixel; registered result.
// ============================================================================
module bsnf_fill #(
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [9*SAMPLE_BITS-1:0] i_win,
    input  bsnf_pkg::t_pix_ctl       i_ctl,
    input  logic                     i_last,
    output bsnf_pkg::t_out_item      o_item
);
    localparam int unsigned SUM_W = SAMPLE_BITS + 3;

    logic [SAMPLE_BITS-1:0] v [9];
    logic [SAMPLE_BITS-1:0] c [9];
    logic                   ysel [3];
    logic                   xsel [3];
    logic [SUM_W-1:0]       res [3];
    bsnf_pkg::t_out_item    r_item;
    bsnf_pkg::t_channel     own;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            v[k] = i_win[k*SAMPLE_BITS +: SAMPLE_BITS];
            c[k] = v[k];
        end
        for (int r = 0; r < 3; r++) begin
            if (i_ctl.left_edge)  c[r*3]   = v[r*3+1];
            if (i_ctl.right_edge) c[r*3+2] = v[r*3+1];
        end
        for (int k = 0; k < 3; k++) begin
            if (i_ctl.top_edge)    c[k]   = c[3+k];
            if (i_ctl.bottom_edge) c[6+k] = c[3+k];
        end
        // clamped neighbour coordinates keep parity of centre on edges
        xsel[1] = i_ctl.col[0];
        xsel[0] = i_ctl.left_edge  ? i_ctl.col[0] : ~i_ctl.col[0];
        xsel[2] = i_ctl.right_edge ? i_ctl.col[0] : ~i_ctl.col[0];
        ysel[1] = i_ctl.row[0];
        ysel[0] = i_ctl.top_edge    ? i_ctl.row[0] : ~i_ctl.row[0];
        ysel[2] = i_ctl.bottom_edge ? i_ctl.row[0] : ~i_ctl.row[0];
        own = bsnf_pkg::colour_of(i_ctl.pattern, ysel[1], xsel[1]);
        for (int ch = 0; ch < 3; ch++) begin
            res[ch] = '0;
            if (own == bsnf_pkg::t_channel'(ch) && c[4] != '0) begin
                res[ch] = {c[4], 3'b000};
            end else begin
                for (int r = 0; r < 3; r++) begin
                    for (int q = 0; q < 3; q++) begin
                        if (!(r == 1 && q == 1) &&
                            bsnf_pkg::colour_of(i_ctl.pattern, ysel[r], xsel[q])
                                == bsnf_pkg::t_channel'(ch)) begin
                            res[ch] = res[ch] + SUM_W'(c[r*3+q]);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item.red_value    <= bsnf_pkg::VAL_W'(res[0]);
            r_item.green_value  <= bsnf_pkg::VAL_W'(res[1]);
            r_item.blue_value   <= bsnf_pkg::VAL_W'(res[2]);
            r_item.pixel_column <= i_ctl.col;
            r_item.pixel_row    <= i_ctl.row;
            r_item.frame_last   <= i_last;
        end
    end

    assign o_item = r_item;
endmodule

@@ design/bayer_split_and_neighbor_fill_core.sv @@
// ============================================================================
// bayer_split_and_neighbor_fill_core
// Streaming Bayer demosaic: two line stores in RAM, a 3x3 window and a fill
// stage giving R, G, B (own colour in eighths, others summed from neighbours).
// ============================================================================
//  channel  dir  payload                              transaction
//  s_in     in   action, sample                       valid & ready
//  m_out    out  rgb values, column, row, frame_last  valid & ready
//  cfg      in   i_cfg_we, i_cfg_idx, i_cfg_data      i_cfg_we high
//
//  One item per cycle while input is ready; both line stores are addressed
//  ahead through the registered RAM by the next-column logic, so each item (or
//  flush step) loads the window when taken; fill registers it when not stalled.
//  Output lags input by one row plus one pixel.
//  A flush whose first internal step emits nothing runs a second step.
//  Input stalls then, and when the output register is full and not taken.
//  Reset clears counters and window; the line stores are not cleared.
module bayer_split_and_neighbor_fill_core #(
    parameter int unsigned MAX_WIDTH   = 4096,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bsnf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bsnf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    bsnf_stream_if.sink                         s_in,
    bsnf_stream_if.source                       m_out
);
    localparam int unsigned AW  = $clog2(MAX_WIDTH);
    localparam int unsigned LIM = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;

    logic [1:0]                   r_pat;
    logic [bsnf_pkg::WID_W-1:0]   r_wid;
    logic [bsnf_pkg::HGT_W-1:0]   r_hgt;
    logic [bsnf_pkg::WID_W-1:0]   eff_w;
    logic [bsnf_pkg::HGT_W-1:0]   eff_h;

    logic [bsnf_pkg::WID_W-1:0]    r_icol, n_icol;
    logic [bsnf_pkg::IN_ROW_W-1:0] r_irow, n_irow;
    logic [bsnf_pkg::COL_W-1:0]    r_ocol, n_ocol;
    logic [bsnf_pkg::ROW_W-1:0]    r_orow, n_orow;
    logic                          r_flush2;

    // stage 2: window valid
    logic                   r_s2_v;
    bsnf_pkg::t_pix_ctl     r_s2_ctl;
    logic                   r_s2_last;
    logic [SAMPLE_BITS-1:0] r_win [9];
    logic [9*SAMPLE_BITS-1:0] win_flat;
    logic                   r_out_v;

    logic [SAMPLE_BITS-1:0] up_rd, mid_rd;
    logic                   step, in_acc, input_done, is_flush, emit, last;
    logic                   ox_last, oy_last;
    logic                   busy_ok, cfg_geo;
    logic [AW-1:0]          col_a;
    logic                   col_ok;
    logic [SAMPLE_BITS-1:0] step_s;
    bsnf_pkg::t_pix_ctl     ctl;
    bsnf_pkg::t_out_item    fill_item;

    // forwarding of pending store writes for the same column
    logic                   r_fw_v;
    logic [AW-1:0]          r_fw_a;
    logic [SAMPLE_BITS-1:0] r_fw_up, r_fw_mid;
    logic [SAMPLE_BITS-1:0] rd_up, rd_mid;

    always_comb begin
        eff_w = r_wid;
        if (r_wid == '0) eff_w = bsnf_pkg::WID_W'(1);
        if (r_wid > bsnf_pkg::WID_W'(LIM)) eff_w = bsnf_pkg::WID_W'(LIM);
        eff_h = r_hgt;
        if (r_hgt == '0) eff_h = bsnf_pkg::HGT_W'(1);
        if (r_hgt > bsnf_pkg::HGT_W'(16384)) eff_h = bsnf_pkg::HGT_W'(16384);
    end

    assign cfg_geo    = i_cfg_we && (i_cfg_idx == bsnf_pkg::REG_WIDTH ||
                                     i_cfg_idx == bsnf_pkg::REG_HEIGHT);
    assign input_done = r_irow >= bsnf_pkg::IN_ROW_W'(eff_h);
    assign is_flush   = s_in.data.action == bsnf_pkg::ACT_FLUSH;

    // pipeline may advance when nothing downstream is blocked
    assign busy_ok    = !r_out_v || m_out.ready;
    assign s_in.ready = busy_ok && !r_flush2;
    assign in_acc     = s_in.valid && s_in.ready;
    assign step       = r_flush2 ? busy_ok
                      : in_acc && (is_flush ? input_done : !input_done);
    assign step_s     = (r_flush2 || is_flush) ? '0 : s_in.data.sample[SAMPLE_BITS-1:0];

    assign emit = (r_irow >= bsnf_pkg::IN_ROW_W'(2)) ||
                  (r_irow == bsnf_pkg::IN_ROW_W'(1) && r_icol != '0);
    assign ox_last = (bsnf_pkg::WID_W'(r_ocol) + 1'b1) >= eff_w;
    assign oy_last = (bsnf_pkg::HGT_W'(r_orow) + 1'b1) >= eff_h;
    assign last    = ox_last && oy_last;
    assign col_ok  = 32'(r_icol) < MAX_WIDTH;
    assign col_a   = AW'(r_icol);

    always_comb begin
        ctl.left_edge   = r_ocol == '0;
        ctl.right_edge  = ox_last;
        ctl.top_edge    = r_orow == '0;
        ctl.bottom_edge = oy_last;
        ctl.col         = r_ocol;
        ctl.row         = r_orow;
        ctl.pattern     = r_pat;
    end

    always_comb begin
        n_icol = r_icol;
        n_irow = r_irow;
        n_ocol = r_ocol;
        n_orow = r_orow;
        if (step) begin
            if (r_icol + 1'b1 >= eff_w) begin
                n_icol = '0;
                n_irow = r_irow + 1'b1;
            end else begin
                n_icol = r_icol + 1'b1;
            end
            if (emit) begin
                if (ox_last) begin
                    n_ocol = '0;
                    n_orow = oy_last ? '0 : r_orow + 1'b1;
                    if (oy_last) begin
                        n_icol = '0;
                        n_irow = '0;
                    end
                end else begin
                    n_ocol = r_ocol + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat    <= '0;
            r_wid    <= bsnf_pkg::WID_W'(4096);
            r_hgt    <= bsnf_pkg::HGT_W'(4096);
            r_icol   <= '0;
            r_irow   <= '0;
            r_ocol   <= '0;
            r_orow   <= '0;
            r_flush2 <= 1'b0;
            r_s2_v   <= 1'b0;
            r_out_v  <= 1'b0;
            r_fw_v   <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == bsnf_pkg::REG_CFA) r_pat <= i_cfg_data[1:0];
            if (i_cfg_we && i_cfg_idx == bsnf_pkg::REG_WIDTH) r_wid <= i_cfg_data[12:0];
            if (i_cfg_we && i_cfg_idx == bsnf_pkg::REG_HEIGHT) r_hgt <= i_cfg_data;
            if (cfg_geo) begin
                r_icol <= '0;
                r_irow <= '0;
                r_ocol <= '0;
                r_orow <= '0;
            end else begin
                r_icol <= n_icol;
                r_irow <= n_irow;
                r_ocol <= n_ocol;
                r_orow <= n_orow;
            end
            // a flush whose first step emits nothing runs a second step
            if (r_flush2) begin
                if (busy_ok) r_flush2 <= 1'b0;
            end else begin
                r_flush2 <= step && is_flush && !emit;
            end
            if (busy_ok) begin
                r_s2_v  <= step && emit;
                r_out_v <= r_s2_v;
            end
            if (step) begin
                r_fw_v <= col_ok;
            end else if (busy_ok) begin
                r_fw_v <= 1'b0;
            end
        end
    end

    // pending write forwarding: previous step wrote the same column
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_fw_a   <= col_a;
            r_fw_up  <= rd_mid;
            r_fw_mid <= step_s;
        end
    end

    // read data of current step, corrected for a write still in flight
    assign rd_up  = !col_ok ? '0 : (r_fw_v && r_fw_a == col_a) ? r_fw_up  : up_rd;
    assign rd_mid = !col_ok ? '0 : (r_fw_v && r_fw_a == col_a) ? r_fw_mid : mid_rd;

    // stores are read ahead through the registered RAM:
    // address is presented by the next-column logic
    logic [AW-1:0] rd_a;
    logic          rd_en;
    assign rd_a  = AW'(n_icol);
    assign rd_en = 1'b1;

    bsnf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (step && col_ok),
        .i_waddr (col_a),
        .i_wdata (rd_mid),
        .i_re    (rd_en),
        .i_raddr (cfg_geo ? '0 : rd_a),
        .o_rdata (up_rd)
    );

    bsnf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_middle (
        .i_clk   (i_clk),
        .i_we    (step && col_ok),
        .i_waddr (col_a),
        .i_wdata (step_s),
        .i_re    (rd_en),
        .i_raddr (cfg_geo ? '0 : rd_a),
        .o_rdata (mid_rd)
    );

    // window shifts on every step; fill registers the shifted window when not stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) r_win[k] <= '0;
        end else if (step) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]   <= r_win[r*3+1];
                r_win[r*3+1] <= r_win[r*3+2];
            end
            r_win[2] <= rd_up;
            r_win[5] <= rd_mid;
            r_win[8] <= step_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_s2_ctl  <= ctl;
            r_s2_last <= last;
        end
    end

    always_comb begin
        for (int k = 0; k < 9; k++) win_flat[k*SAMPLE_BITS +: SAMPLE_BITS] = r_win[k];
    end

    bsnf_fill #(.SAMPLE_BITS(SAMPLE_BITS)) u_fill (
        .i_clk  (i_clk),
        .i_en   (busy_ok && r_s2_v),
        .i_win  (win_flat),
        .i_ctl  (r_s2_ctl),
        .i_last (r_s2_last),
        .o_item (fill_item)
    );

    assign m_out.valid = r_out_v;
    assign m_out.data  = fill_item;
endmodule

@@ tb/sv/bsnf_checker.sv @@
// ----------------------------------------------------------------------------
// bsnf_checker
// Watches the sample and pixel channels and the register port of the demosaic
// core, predicts every emitted pixel and compares it field by field.
// ----------------------------------------------------------------------------
module bsnf_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bsnf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bsnf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  bsnf_pkg::t_in_item              i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  bsnf_pkg::t_out_item             i_out_data,
    output int unsigned                     o_pending,
    output int unsigned                     o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LINE_DEPTH = 4096;

    // which colour owns each 2x2 position {row bit, column bit}, per layout
    localparam bsnf_pkg::t_channel PLANE_OWNER [4][4] = '{
        '{bsnf_pkg::t_CH_RED,   bsnf_pkg::t_CH_GREEN, bsnf_pkg::t_CH_GREEN, bsnf_pkg::t_CH_BLUE},
        '{bsnf_pkg::t_CH_BLUE,  bsnf_pkg::t_CH_GREEN, bsnf_pkg::t_CH_GREEN, bsnf_pkg::t_CH_RED},
        '{bsnf_pkg::t_CH_GREEN, bsnf_pkg::t_CH_RED,   bsnf_pkg::t_CH_BLUE,  bsnf_pkg::t_CH_GREEN},
        '{bsnf_pkg::t_CH_GREEN, bsnf_pkg::t_CH_BLUE,  bsnf_pkg::t_CH_RED,   bsnf_pkg::t_CH_GREEN}
    };

    logic [15:0]          upper_line  [LINE_DEPTH];
    logic [15:0]          middle_line [LINE_DEPTH];
    logic [15:0]          window      [9];
    logic [1:0]           layout;
    int unsigned          width_reg, height_reg;
    int unsigned          in_col, in_row, out_col, out_row;
    bsnf_pkg::t_out_item  pixel_q [$];
    int unsigned          errors;

    assign o_pending = pixel_q.size();
    assign o_errors  = errors;

    function automatic int unsigned frame_w();
        if (width_reg < 1) return 1;
        if (width_reg > LINE_DEPTH) return LINE_DEPTH;
        return width_reg;
    endfunction

    function automatic int unsigned frame_h();
        if (height_reg < 1) return 1;
        if (height_reg > 16384) return 16384;
        return height_reg;
    endfunction

    function automatic bsnf_pkg::t_out_item fill_pixel(input int unsigned w,
                                                       input int unsigned h);
        int unsigned         ox, oy, acc;
        int unsigned         v [9];
        int unsigned         xs [3];
        int unsigned         ys [3];
        bsnf_pkg::t_channel  own;
        bsnf_pkg::t_out_item px;
        ox = out_col;
        oy = out_row;
        for (int k = 0; k < 9; k++) v[k] = window[k];
        xs[0] = (ox != 0) ? ox - 1 : ox;
        xs[1] = ox;
        xs[2] = (ox + 1 < w) ? ox + 1 : ox;
        ys[0] = (oy != 0) ? oy - 1 : oy;
        ys[1] = oy;
        ys[2] = (oy + 1 < h) ? oy + 1 : oy;
        // border clamp replicates the center row or column
        for (int r = 0; r < 3; r++) begin
            if (ox == 0) v[r*3] = v[r*3+1];
            if (ox + 1 >= w) v[r*3+2] = v[r*3+1];
        end
        for (int c = 0; c < 3; c++) begin
            if (oy == 0) v[c] = v[3+c];
            if (oy + 1 >= h) v[6+c] = v[3+c];
        end
        own = PLANE_OWNER[layout][{ys[1][0], xs[1][0]}];
        for (int ch = 0; ch < 3; ch++) begin
            acc = 0;
            if (own == bsnf_pkg::t_channel'(ch) && v[4] != 0) begin
                acc = v[4] * 8;
            end else begin
                for (int r = 0; r < 3; r++)
                    for (int c = 0; c < 3; c++)
                        if (!(r == 1 && c == 1) &&
                            PLANE_OWNER[layout][{ys[r][0], xs[c][0]}]
                                == bsnf_pkg::t_channel'(ch))
                            acc += v[r*3+c];
            end
            case (bsnf_pkg::t_channel'(ch))
                bsnf_pkg::t_CH_RED:   px.red_value   = acc[bsnf_pkg::VAL_W-1:0];
                bsnf_pkg::t_CH_GREEN: px.green_value = acc[bsnf_pkg::VAL_W-1:0];
                default:              px.blue_value  = acc[bsnf_pkg::VAL_W-1:0];
            endcase
        end
        px.pixel_column = ox[bsnf_pkg::COL_W-1:0];
        px.pixel_row    = oy[bsnf_pkg::ROW_W-1:0];
        px.frame_last   = (ox + 1 >= w) && (oy + 1 >= h);
        if (ox + 1 >= w) begin
            out_col = 0;
            if (oy + 1 >= h) begin
                in_col = 0; in_row = 0; out_row = 0;
            end else begin
                out_row = oy + 1;
            end
        end else begin
            out_col = ox + 1;
        end
        return px;
    endfunction

    // shift one sample into the line stores and window; queues a pixel if one is due
    function automatic bit shift_in(input logic [15:0] s);
        int unsigned w, h, ix;
        logic [15:0] up, mid;
        bit          due;
        w = frame_w();
        h = frame_h();
        ix = in_col;
        up = '0;
        mid = '0;
        if (ix < LINE_DEPTH) begin
            up = upper_line[ix];
            mid = middle_line[ix];
            upper_line[ix] = mid;
            middle_line[ix] = s;
        end
        for (int r = 0; r < 3; r++) begin
            window[r*3]   = window[r*3+1];
            window[r*3+1] = window[r*3+2];
        end
        window[2] = up;
        window[5] = mid;
        window[8] = s;
        due = (in_row >= 2) || (in_row == 1 && in_col >= 1);
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (due) pixel_q.push_back(fill_pixel(w, h));
        return due;
    endfunction

    task automatic report(input string what, input int unsigned got, input int unsigned want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        bsnf_pkg::t_out_item want;
        bit                  done;
        if (!i_rst_n) begin
            layout = 2'd0;
            width_reg = 4096;
            height_reg = 4096;
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
            for (int k = 0; k < 9; k++) window[k] = '0;
            for (int k = 0; k < LINE_DEPTH; k++) begin
                upper_line[k] = '0;
                middle_line[k] = '0;
            end
            pixel_q.delete();
            errors = 0;
        end else begin
            // compare before predicting so a same-edge transaction sees the older queue
            if (i_out_valid && i_out_ready) begin
                if (pixel_q.size() == 0) begin
                    report("unexpected pixel count", 1, 0);
                end else begin
                    want = pixel_q.pop_front();
                    if (i_out_data.red_value !== want.red_value)
                        report("red_value", i_out_data.red_value, want.red_value);
                    if (i_out_data.green_value !== want.green_value)
                        report("green_value", i_out_data.green_value, want.green_value);
                    if (i_out_data.blue_value !== want.blue_value)
                        report("blue_value", i_out_data.blue_value, want.blue_value);
                    if (i_out_data.pixel_column !== want.pixel_column)
                        report("pixel_column", i_out_data.pixel_column, want.pixel_column);
                    if (i_out_data.pixel_row !== want.pixel_row)
                        report("pixel_row", i_out_data.pixel_row, want.pixel_row);
                    if (i_out_data.frame_last !== want.frame_last)
                        report("frame_last", i_out_data.frame_last, want.frame_last);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bsnf_pkg::REG_CFA: layout = i_cfg_data[1:0];
                    bsnf_pkg::REG_WIDTH: begin
                        width_reg = i_cfg_data[bsnf_pkg::WID_W-1:0];
                        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
                    end
                    bsnf_pkg::REG_HEIGHT: begin
                        height_reg = i_cfg_data[bsnf_pkg::HGT_W-1:0];
                        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
                    end
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                done = in_row >= frame_h();
                if (i_in_data.action == bsnf_pkg::ACT_SAMPLE) begin
                    if (!done) void'(shift_in(i_in_data.sample));
                end else if (done) begin
                    // a flush whose first step emits nothing takes a second step
                    if (!shift_in('0)) void'(shift_in('0));
                end
            end
        end
    end
endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives raw frames, flushes and register writes into the demosaic core with
// random stalls on both channels; the checker predicts and compares pixels.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STALL_LIMIT = 3000;
    localparam int unsigned ITEM_TARGET = 1450;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [bsnf_pkg::CFG_IDX_W-1:0]  i_cfg_idx = bsnf_pkg::REG_CFA;
    logic [bsnf_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    int unsigned                     pending, errors;
    int unsigned                     item_cnt = 0;
    int unsigned                     quiet_cycles = 0;
    int unsigned                     sink_hold = 0;
    bit                              calm = 1'b0;
    int unsigned                     cur_w = 4096, cur_h = 4096;

    bsnf_stream_if #(.T(bsnf_pkg::t_in_item))  raw_if ();
    bsnf_stream_if #(.T(bsnf_pkg::t_out_item)) pix_if ();

    bayer_split_and_neighbor_fill_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_in       (raw_if.sink),
        .m_out      (pix_if.source)
    );

    bsnf_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (raw_if.valid),
        .i_in_ready  (raw_if.ready),
        .i_in_data   (raw_if.data),
        .i_out_valid (pix_if.valid),
        .i_out_ready (pix_if.ready),
        .i_out_data  (pix_if.data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        raw_if.valid = 1'b0;
        raw_if.data  = '0;
        pix_if.ready = 1'b0;
    end

    // pixel sink with random stall bursts
    always @(posedge i_clk) begin
        if (calm) begin
            pix_if.ready <= 1'b1;
        end else if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
            pix_if.ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            sink_hold <= $urandom_range(0, 9);
            pix_if.ready <= 1'b0;
        end else begin
            pix_if.ready <= 1'b1;
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((raw_if.valid && raw_if.ready) || (pix_if.valid && pix_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[bayer_split_and_neighbor_fill_core] ERROR");
                $finish;
            end
        end
    end

    task automatic send(input logic act, input logic [15:0] smp);
        bsnf_pkg::t_in_item it;
        if (!calm && $urandom_range(0, 5) == 0) begin
            raw_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        it.action = act;
        it.sample = smp;
        raw_if.valid <= 1'b1;
        raw_if.data  <= it;
        @(negedge i_clk);
        while (!raw_if.ready) @(negedge i_clk);
        @(posedge i_clk);
        item_cnt++;
    endtask

    // stop sending, let every expected pixel arrive, then let the pipe settle
    task automatic settle();
        raw_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [bsnf_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[bsnf_pkg::CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == bsnf_pkg::REG_WIDTH) cur_w = (val == 0) ? 1 : (val > 4096) ? 4096 : val;
        if (idx == bsnf_pkg::REG_HEIGHT) cur_h = (val == 0) ? 1 : (val > 16384) ? 16384 : val;
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic geometry(input int unsigned w, input int unsigned h);
        write_reg(bsnf_pkg::REG_WIDTH, w);
        write_reg(bsnf_pkg::REG_HEIGHT, h);
    endtask

    // one whole frame, optionally sprinkled with ignored items
    task automatic run_frame(input bit noisy);
        for (int unsigned k = 0; k < cur_w * cur_h; k++) begin
            if (noisy && $urandom_range(0, 15) == 0)
                send(bsnf_pkg::ACT_FLUSH, 16'($urandom));
            send(bsnf_pkg::ACT_SAMPLE, pick_sample());
        end
        if (noisy) send(bsnf_pkg::ACT_SAMPLE, pick_sample());
        for (int unsigned k = 0; k <= cur_w; k++) send(bsnf_pkg::ACT_FLUSH, 16'($urandom));
    endtask

    initial begin
        int unsigned sel;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: small frame with extreme samples and ignored items
        write_reg(bsnf_pkg::REG_CFA, 0);
        geometry(3, 2);
        send(bsnf_pkg::ACT_FLUSH, 16'h0000);
        send(bsnf_pkg::ACT_SAMPLE, 16'h0000);
        send(bsnf_pkg::ACT_SAMPLE, 16'hFFFF);
        send(bsnf_pkg::ACT_SAMPLE, 16'hAAAA);
        send(bsnf_pkg::ACT_SAMPLE, 16'h5555);
        send(bsnf_pkg::ACT_SAMPLE, 16'h0000);
        send(bsnf_pkg::ACT_SAMPLE, 16'hFFFF);
        send(bsnf_pkg::ACT_SAMPLE, 16'h1234);
        for (int k = 0; k < 4; k++) send(bsnf_pkg::ACT_FLUSH, 16'hFFFF);
        send(bsnf_pkg::ACT_FLUSH, 16'h0000);
        settle();
        // single-row frame, other layout
        write_reg(bsnf_pkg::REG_CFA, 3);
        geometry(2, 1);
        send(bsnf_pkg::ACT_SAMPLE, 16'hFFFF);
        send(bsnf_pkg::ACT_SAMPLE, 16'h0001);
        send(bsnf_pkg::ACT_FLUSH, 16'h0000);
        send(bsnf_pkg::ACT_FLUSH, 16'h0000);
        settle();
        // zero geometry acts as one pixel
        write_reg(bsnf_pkg::REG_CFA, 1);
        geometry(0, 0);
        send(bsnf_pkg::ACT_SAMPLE, 16'h8001);
        send(bsnf_pkg::ACT_FLUSH, 16'h0000);
        send(bsnf_pkg::ACT_FLUSH, 16'h0000);
        settle();

        // oversized width clamps; row abandoned by a geometry rewrite
        write_reg(bsnf_pkg::REG_CFA, 2);
        geometry(8191, 1);
        for (int k = 0; k < 20; k++) send(bsnf_pkg::ACT_SAMPLE, pick_sample());
        settle();
        // tallest frame, abandoned by a geometry rewrite
        geometry(1, 16384);
        for (int k = 0; k < 5; k++) send(bsnf_pkg::ACT_SAMPLE, pick_sample());
        settle();
        geometry(4096, 2);
        for (int k = 0; k < 20; k++) send(bsnf_pkg::ACT_SAMPLE, pick_sample());
        settle();
        // oversized height clamps
        geometry(2, 32767);
        for (int k = 0; k < 8; k++) send(bsnf_pkg::ACT_SAMPLE, pick_sample());
        settle();
        geometry(4, 3);

        while (item_cnt < ITEM_TARGET) begin
            if (item_cnt > ITEM_TARGET - 200) calm = 1'b1;
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                settle();
                write_reg(bsnf_pkg::REG_CFA, $urandom_range(0, 3));
            end else if (sel == 1) begin
                // broken frame: stop part way and change geometry
                for (int unsigned k = $urandom_range(1, cur_w * cur_h); k > 0; k--)
                    send(bsnf_pkg::ACT_SAMPLE, pick_sample());
                settle();
                geometry($urandom_range(1, 8), $urandom_range(1, 6));
            end else begin
                if (sel == 2) begin
                    settle();
                    geometry($urandom_range(1, 8), $urandom_range(1, 6));
                end
                run_frame(sel == 3);
            end
        end
        raw_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("[bayer_split_and_neighbor_fill_core] OK");
        end else begin
            $display("[bayer_split_and_neighbor_fill_core] ERROR");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
design/bsnf_pkg.sv
design/bsnf_stream_if.sv
design/bsnf_ram.sv
design/bsnf_fill.sv
design/bayer_split_and_neighbor_fill_core.sv
tb/sv/bsnf_checker.sv
tb/sv/testbench.sv
